// ===== rtl/assert_macros.svh =====
// assert_macros.svh: assertion macros used by the checker file pidaw_chk.sv.
// No dependencies; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held (active low).
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pidaw_pkg.sv =====
// pidaw_pkg: widths, register indices and divider handshake types
// for the PID step block. No dependencies.
`timescale 1ns / 1ps

package pidaw_pkg;

    localparam int DATA_W    = 32;  // Q16.16 words
    localparam int DT_W      = 16;  // Q0.16 time step
    localparam int LIMIT_W   = 31;  // integral bound
    localparam int CFG_IDX_W = 3;

    // Divider: (|diff| << 16) / dt, two quotient bits a cycle
    localparam int DIV_BITS  = DATA_W + 16;
    localparam int DIV_STEP  = 2;
    localparam int DIV_ITER  = DIV_BITS / DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_ITER);

    // Configuration register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_LIMIT     = 3'd3,
        CFG_CLAMP_ON  = 3'd4,
        CFG_FF_GAIN   = 3'd5,
        CFG_FF_ON     = 3'd6
    } t_cfg_idx;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic              neg;
        logic [DATA_W-1:0] mag;
        logic [DT_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== rtl/pidaw_cmd_if.sv =====
// pidaw_cmd_if: input item channel of the PID step block.
// Depends on pidaw_pkg.
`timescale 1ns / 1ps

interface pidaw_cmd_if import pidaw_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] error_value;
    logic [DT_W-1:0]          time_step;
    logic signed [DATA_W-1:0] feedforward_sample;

    modport source (output valid, output error_value, output time_step,
                    output feedforward_sample, input ready);
    modport sink   (input valid, input error_value, input time_step,
                    input feedforward_sample, output ready);
endinterface

// ===== rtl/pidaw_res_if.sv =====
// pidaw_res_if: result item channel of the PID step block.
// Depends on pidaw_pkg.
`timescale 1ns / 1ps

interface pidaw_res_if import pidaw_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive_value;
    logic                     step_skipped;

    modport source (output valid, output drive_value, output step_skipped,
                    input ready);
    modport sink   (input valid, input drive_value, input step_skipped,
                    output ready);
endinterface

// ===== rtl/pidaw_div.sv =====
// pidaw_div: sign-magnitude restoring divider for the derivative term,
// two quotient bits a cycle, result saturated to 32 bits. Uses pidaw_pkg.
`timescale 1ns / 1ps

module pidaw_div import pidaw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam logic [DIV_BITS-1:0] POS_MAX = DIV_BITS'(48'h0000_7FFF_FFFF);
    localparam logic [DIV_BITS-1:0] NEG_MAX = DIV_BITS'(48'h0000_8000_0000);

    logic [DIV_BITS-1:0]  r_num;
    logic [DIV_BITS-1:0]  r_quot;
    logic [DT_W-1:0]      r_rem;
    logic [DT_W-1:0]      r_div;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DT_W-1:0]      n_rem;
    logic [DIV_STEP-1:0]  n_qbits;
    logic [DATA_W-1:0]    sat_q;

    // Two restoring steps per cycle
    always_comb begin
        logic [DT_W:0] rem_ext;
        n_rem   = r_rem;
        n_qbits = '0;
        for (int k = 0; k < DIV_STEP; k++) begin
            rem_ext = {n_rem, r_num[DIV_BITS-1-k]};
            if (rem_ext >= {1'b0, r_div}) begin
                rem_ext = rem_ext - {1'b0, r_div};
                n_qbits[DIV_STEP-1-k] = 1'b1;
            end
            n_rem = rem_ext[DT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_num  <= {i_req.mag, 16'd0};
            r_quot <= '0;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
            r_neg  <= i_req.neg;
        end else if (r_busy) begin
            r_num  <= {r_num[DIV_BITS-DIV_STEP-1:0], {DIV_STEP{1'b0}}};
            r_quot <= {r_quot[DIV_BITS-DIV_STEP-1:0], n_qbits};
            r_rem  <= n_rem;
            r_cnt  <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_ITER - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Apply sign and saturate to the signed 32-bit range
    always_comb begin
        if (r_neg) begin
            sat_q = (r_quot > NEG_MAX) ? 32'h8000_0000 : (~r_quot[DATA_W-1:0] + 1'b1);
        end else begin
            sat_q = (r_quot > POS_MAX) ? 32'h7FFF_FFFF : r_quot[DATA_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = sat_q;

endmodule

// ===== rtl/pid_step_anti_windup.sv =====
// pid_step_anti_windup: microcoded PID step with integral clamp and feedforward.
// Depends on pidaw_pkg, pidaw_cmd_if, pidaw_res_if and pidaw_div.
//
//   port     dir  handshake      carries
//   i_cmd    in   valid/ready    error_value, time_step, feedforward_sample
//   o_res    out  valid/ready    drive_value, step_skipped
//   i_cfg_*  in   write enable   register index, 32-bit write data
//
// One item at a time: a normal item runs through the microcode steps and waits at
// PC_WAIT_D for the two-bit-a-cycle divider that forms the derivative.
// A zero time step goes straight to the skip step, which gives its skip result.
// The next item is taken as soon as the result sits in the output register.
// If the output register is full and not being read, the last step waits there.
// Reset is synchronous and active low; it clears state and loads register defaults.
`timescale 1ns / 1ps

module pid_step_anti_windup import pidaw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pidaw_cmd_if.sink            i_cmd,
    pidaw_res_if.source          o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = 50;   // four Q32.16 terms
    localparam int INT_W  = 34;   // integral plus one e*dt term
    localparam int PC_W   = 4;

    // Microcode step addresses
    localparam logic [PC_W-1:0] PC_START  = 4'd0;
    localparam logic [PC_W-1:0] PC_INTEG  = 4'd1;
    localparam logic [PC_W-1:0] PC_ACC_P  = 4'd2;
    localparam logic [PC_W-1:0] PC_ACC_I  = 4'd3;
    localparam logic [PC_W-1:0] PC_WAIT_D = 4'd4;
    localparam logic [PC_W-1:0] PC_MUL_D  = 4'd5;
    localparam logic [PC_W-1:0] PC_ACC_D  = 4'd6;
    localparam logic [PC_W-1:0] PC_ACC_F  = 4'd7;
    localparam logic [PC_W-1:0] PC_EMIT   = 4'd8;
    localparam logic [PC_W-1:0] PC_SKIP   = 4'd9;

    localparam logic signed [INT_W-1:0] INT_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [INT_W-1:0] INT_MIN = -34'sh0_8000_0000;
    localparam logic signed [ACC_W-1:0] ACC_MAX = 50'sh0_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -50'sh0_0000_8000_0000;

    typedef enum logic [2:0] {MS_E_DT, MS_GP_E, MS_GI_I, MS_GD_D, MS_FF} t_mul_sel;
    typedef enum logic [1:0] {AC_NONE, AC_LOAD, AC_ADD, AC_ADD_FF} t_acc_op;
    typedef enum logic [1:0] {HC_NONE, HC_DIV, HC_OUT} t_hold;
    typedef enum logic [1:0] {EM_NONE, EM_DRIVE, EM_SKIP} t_emit;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     integ_wr;
        logic     div_start;
        logic     deriv_wr;
        t_hold    hold;
        t_emit    emit;
    } t_uword;

    // Control store
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w.mul_sel   = MS_E_DT;
        w.acc_op    = AC_NONE;
        w.integ_wr  = 1'b0;
        w.div_start = 1'b0;
        w.deriv_wr  = 1'b0;
        w.hold      = HC_NONE;
        w.emit      = EM_NONE;
        case (pc)
            PC_START: begin
                w.mul_sel   = MS_E_DT;
                w.div_start = 1'b1;
            end
            PC_INTEG: begin
                w.integ_wr = 1'b1;
                w.mul_sel  = MS_GP_E;
            end
            PC_ACC_P: begin
                w.acc_op  = AC_LOAD;
                w.mul_sel = MS_GI_I;
            end
            PC_ACC_I: begin
                w.acc_op = AC_ADD;
            end
            PC_WAIT_D: begin
                w.hold     = HC_DIV;
                w.deriv_wr = 1'b1;
            end
            PC_MUL_D: begin
                w.mul_sel = MS_GD_D;
            end
            PC_ACC_D: begin
                w.acc_op  = AC_ADD;
                w.mul_sel = MS_FF;
            end
            PC_ACC_F: begin
                w.acc_op = AC_ADD_FF;
            end
            PC_EMIT: begin
                w.hold = HC_OUT;
                w.emit = EM_DRIVE;
            end
            PC_SKIP: begin
                w.hold = HC_OUT;
                w.emit = EM_SKIP;
            end
            default: begin
                w.emit = EM_SKIP;
            end
        endcase
        return w;
    endfunction

    // Configuration registers
    logic signed [DATA_W-1:0] r_gain_p;
    logic signed [DATA_W-1:0] r_gain_i;
    logic signed [DATA_W-1:0] r_gain_d;
    logic [LIMIT_W-1:0]       r_limit;
    logic                     r_clamp_on;
    logic signed [DATA_W-1:0] r_ff_gain;
    logic                     r_ff_on;

    // Sequencer and datapath
    logic [PC_W-1:0]          r_pc;
    logic                     r_busy;
    logic signed [DATA_W-1:0] r_e;
    logic [DT_W-1:0]          r_dt;
    logic signed [DATA_W-1:0] r_ff;
    logic signed [DATA_W-1:0] r_integ;
    logic signed [DATA_W-1:0] r_prev;
    logic signed [DATA_W-1:0] r_deriv;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_drive;
    logic                     r_out_skip;

    t_uword                   uw;
    logic                     hold;
    logic                     in_fire;
    logic                     step_go;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [ACC_W-1:0]  term;
    logic signed [INT_W-1:0]  int_sum;
    logic signed [INT_W-1:0]  lim_pos;
    logic signed [INT_W-1:0]  lim_neg;
    logic signed [DATA_W-1:0] n_integ;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [DATA_W-1:0] drive_sat;
    logic signed [DATA_W:0]   diff;
    logic [DATA_W:0]          diff_mag;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;

    // Register writes; unknown indices are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
            r_limit    <= '1;
            r_clamp_on <= 1'b0;
            r_ff_gain  <= '0;
            r_ff_on    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_P:   r_gain_p   <= i_cfg_data;
                CFG_GAIN_I:   r_gain_i   <= i_cfg_data;
                CFG_GAIN_D:   r_gain_d   <= i_cfg_data;
                CFG_LIMIT:    r_limit    <= i_cfg_data[LIMIT_W-1:0];
                CFG_CLAMP_ON: r_clamp_on <= i_cfg_data[0];
                CFG_FF_GAIN:  r_ff_gain  <= i_cfg_data;
                CFG_FF_ON:    r_ff_on    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Current control word and step condition
    assign uw      = ucode(r_pc);
    assign hold    = ((uw.hold == HC_DIV) && !div_rsp.done) ||
                     ((uw.hold == HC_OUT) && r_out_valid && !o_res.ready);
    assign step_go = r_busy && !hold;
    assign in_fire = i_cmd.valid && i_cmd.ready;

    // Shared multiplier operand select
    always_comb begin
        case (uw.mul_sel)
            MS_E_DT: begin
                mul_a = r_e;
                mul_b = $signed({{(DATA_W-DT_W){1'b0}}, r_dt});
            end
            MS_GP_E: begin
                mul_a = r_gain_p;
                mul_b = r_e;
            end
            MS_GI_I: begin
                mul_a = r_gain_i;
                mul_b = r_integ;
            end
            MS_GD_D: begin
                mul_a = r_gain_d;
                mul_b = r_deriv;
            end
            MS_FF: begin
                mul_a = r_ff_gain;
                mul_b = r_ff;
            end
            default: begin
                mul_a = r_e;
                mul_b = r_e;
            end
        endcase
    end

    // Product with 16 fraction bits dropped (floor)
    assign term = {{(ACC_W-(PROD_W-16)){r_prod[PROD_W-1]}}, r_prod[PROD_W-1:16]};

    // Integral update: clamp to the limit, or saturate at 32 bits
    assign int_sum = {{(INT_W-DATA_W){r_integ[DATA_W-1]}}, r_integ} + r_prod[INT_W+15:16];
    assign lim_pos = $signed({{(INT_W-LIMIT_W){1'b0}}, r_limit});
    assign lim_neg = -lim_pos;

    always_comb begin
        if (r_clamp_on) begin
            if (int_sum > lim_pos) begin
                n_integ = lim_pos[DATA_W-1:0];
            end else if (int_sum < lim_neg) begin
                n_integ = lim_neg[DATA_W-1:0];
            end else begin
                n_integ = int_sum[DATA_W-1:0];
            end
        end else begin
            if (int_sum > INT_MAX) begin
                n_integ = INT_MAX[DATA_W-1:0];
            end else if (int_sum < INT_MIN) begin
                n_integ = INT_MIN[DATA_W-1:0];
            end else begin
                n_integ = int_sum[DATA_W-1:0];
            end
        end
    end

    // Term accumulator
    always_comb begin
        case (uw.acc_op)
            AC_LOAD:   n_acc = term;
            AC_ADD:    n_acc = r_acc + term;
            AC_ADD_FF: n_acc = r_ff_on ? (r_acc + term) : r_acc;
            default:   n_acc = r_acc;
        endcase
    end

    // Final saturation of the sum
    always_comb begin
        if (r_acc > ACC_MAX) begin
            drive_sat = ACC_MAX[DATA_W-1:0];
        end else if (r_acc < ACC_MIN) begin
            drive_sat = ACC_MIN[DATA_W-1:0];
        end else begin
            drive_sat = r_acc[DATA_W-1:0];
        end
    end

    // Derivative numerator in sign-magnitude form
    assign diff     = {r_e[DATA_W-1], r_e} - {r_prev[DATA_W-1], r_prev};
    assign diff_mag = diff[DATA_W] ? (~diff + 1'b1) : diff;

    assign div_req.start   = step_go && uw.div_start;
    assign div_req.neg     = diff[DATA_W];
    assign div_req.mag     = diff_mag[DATA_W-1:0];
    assign div_req.divisor = r_dt;

    pidaw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (in_fire) begin
            r_e  <= i_cmd.error_value;
            r_dt <= i_cmd.time_step;
            r_ff <= i_cmd.feedforward_sample;
        end
        if (step_go) begin
            r_acc <= n_acc;
            if (uw.deriv_wr) begin
                r_deriv <= div_rsp.quot;
            end
        end
    end

    // Sequencer, controller state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= PC_START;
            r_integ     <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a taken result frees the register unless a new one lands now
            if (o_res.valid && o_res.ready && !(step_go && (uw.emit != EM_NONE))) begin
                r_out_valid <= 1'b0;
            end
            if (in_fire) begin
                r_busy <= 1'b1;
                r_pc   <= (i_cmd.time_step == '0) ? PC_SKIP : PC_START;
            end else if (step_go) begin
                if (uw.integ_wr) begin
                    r_integ <= n_integ;
                end
                case (uw.emit)
                    EM_DRIVE: begin
                        r_busy      <= 1'b0;
                        r_prev      <= r_e;
                        r_out_valid <= 1'b1;
                        r_out_drive <= drive_sat;
                        r_out_skip  <= 1'b0;
                    end
                    EM_SKIP: begin
                        r_busy      <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_out_drive <= '0;
                        r_out_skip  <= 1'b1;
                    end
                    default: begin
                        r_pc <= r_pc + 1'b1;
                    end
                endcase
            end
        end
    end

    assign i_cmd.ready        = !r_busy;
    assign o_res.valid        = r_out_valid;
    assign o_res.drive_value  = r_out_drive;
    assign o_res.step_skipped = r_out_skip;

endmodule

// ===== rtl/pidaw_chk.sv =====
// pidaw_chk: port-level assertions for pid_step_anti_windup, bound to it below.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pidaw_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_drive_value,
    input logic        i_step_skipped
);

    // A skipped step always reports a zero drive
    `ASSERT_CLK(a_skip_zero, i_clk, i_rst_n, (i_out_valid && i_step_skipped) |-> (i_drive_value == 32'd0), "skipped item with nonzero drive")

    // Once an item is taken the block is busy with it
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "ready stayed high after an item was taken")

    // A stalled result stays put
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_drive_value) && $stable(i_step_skipped)), "stalled result changed")

    // Reset empties the output register
    `ASSERT_CLK_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid right after reset")

endmodule

bind pid_step_anti_windup pidaw_chk u_pidaw_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_cmd.valid),
    .i_in_ready     (i_cmd.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_drive_value  (o_res.drive_value),
    .i_step_skipped (o_res.step_skipped)
);
